// ===== hw/rtl/kwm_pkg.sv =====
package kwm_pkg;

	localparam int RUN_W       = 3;
	localparam int KEY_HIGH_W  = 16;
	localparam int KEY_LOW_W   = 64;
	localparam int KEY_W       = KEY_HIGH_W + KEY_LOW_W;
	localparam int RUN_COUNT_W = 4;

	localparam logic [RUN_COUNT_W-1:0] RUN_COUNT_RESET = 4'd8;

	// operation codes of an input item
	localparam logic OP_HEAD = 1'b0;
	localparam logic OP_END  = 1'b1;

	typedef struct packed {
		logic                  operation;
		logic [RUN_W-1:0]      run;
		logic [KEY_HIGH_W-1:0] key_high;
		logic [KEY_LOW_W-1:0]  key_low;
	} item_t;

	typedef struct packed {
		logic [RUN_W-1:0]      winner_run;
		logic [KEY_HIGH_W-1:0] out_key_high;
		logic [KEY_LOW_W-1:0]  out_key_low;
		logic                  done_res;
	} result_t;

endpackage

// ===== hw/rtl/kwm_ram.sv =====
module kwm_ram
	#(
		parameter int WIDTH = 80,
		parameter int DEPTH = 8
	)
	(
		input  logic                     clk,
		input  logic                     wr_en,
		input  logic [$clog2(DEPTH)-1:0] wr_addr,
		input  logic [WIDTH-1:0]         wr_data,
		input  logic                     rd_en,
		input  logic [$clog2(DEPTH)-1:0] rd_addr,
		output logic [WIDTH-1:0]         rd_data
	);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

// ===== hw/rtl/kway_sorted_run_merger_top.sv =====
// K-way merge of sorted runs by 80-bit keys (unsigned, big-endian bytes).
// Input channel (item_valid / item_stall / item): each item offers the next
// head key of one run or marks that run as ended. Once every active run holds
// a head or has ended, one result leaves on the output channel
// (result_valid / result_stall / result): the smallest head with its run
// index (lowest index on ties), or a done result when all runs have ended.
// Config channel (cfg_valid / cfg_ready / cfg_data) writes run_count; write
// it only while the block is idle.
// Steps: the item is latched, a check follows, then the n active heads
// (n = active run count) are read in turn from the head RAM through the
// single 80-bit comparator, the registered read is drained, and the output
// register is loaded. A done result skips the reads, and an item that yields
// no result returns to idle after the check.
// item_stall is high while the sequencer is busy. The output register lets
// the next item in while a result waits; a stalled result holds, and the
// sequencer waits in its final state until the register frees up.
// Reset clears all flags and the output valid flag and sets run_count to 8.
module kway_sorted_run_merger_top
	import kwm_pkg::*;
	#(
		parameter int MAX_RUNS = 8
	)
	(
		input  logic                   clk,
		input  logic                   arst_n,
		input  logic                   item_valid,
		output logic                   item_stall,
		input  item_t                  item,
		output logic                   result_valid,
		input  logic                   result_stall,
		output result_t                result,
		input  logic                   cfg_valid,
		output logic                   cfg_ready,
		input  logic [RUN_COUNT_W-1:0] cfg_data
	);

	localparam int RUN_IDX_W = $clog2(MAX_RUNS);
	localparam int CNT_W     = $clog2(MAX_RUNS + 1);
	localparam int CMP_W     = (CNT_W > RUN_COUNT_W) ? CNT_W : RUN_COUNT_W;

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_CHECK = 5'b00010,
		ST_SCAN  = 5'b00100,
		ST_DRAIN = 5'b01000,
		ST_EMIT  = 5'b10000
	} state_t;

	state_t                 state_q;
	logic [RUN_COUNT_W-1:0] run_count_q;
	logic [MAX_RUNS-1:0]    head_present_q;
	logic [MAX_RUNS-1:0]    run_finished_q;
	logic [CMP_W-1:0]       cnt_q;
	logic                   found_q;
	logic                   done_q;
	logic                   sel_s1;
	logic [RUN_IDX_W-1:0]   idx_s1;
	logic [KEY_W-1:0]       best_key_q;
	logic [RUN_IDX_W-1:0]   best_idx_q;
	logic                   result_valid_q;
	result_t                result_q;

	logic [CMP_W-1:0]     n_w;
	logic [CMP_W-1:0]     rc_ext;
	logic [MAX_RUNS-1:0]  active_w;
	logic                 covered_w;
	logic                 all_fin_w;
	logic                 accept_w;
	logic                 run_ok_w;
	logic [RUN_IDX_W-1:0] run_addr_w;
	logic                 busy_w;
	logic                 wr_head_w;
	logic                 wr_end_w;
	logic [RUN_IDX_W-1:0] rd_addr_w;
	logic                 rd_en_w;
	logic [KEY_W-1:0]     rd_data_w;
	logic                 take_w;
	logic                 slot_free_w;
	logic                 last_w;

	always_comb begin
		rc_ext = CMP_W'(run_count_q);
		if (rc_ext == '0) begin
			n_w = CMP_W'(1);
		end else if (rc_ext > CMP_W'(MAX_RUNS)) begin
			n_w = CMP_W'(MAX_RUNS);
		end else begin
			n_w = rc_ext;
		end
		for (int i = 0; i < MAX_RUNS; i++) begin
			active_w[i] = CMP_W'(i) < n_w;
		end
	end

	assign covered_w = ((head_present_q | run_finished_q) & active_w) == active_w;
	assign all_fin_w = (run_finished_q & active_w) == active_w;

	assign item_stall = state_q != ST_IDLE;
	assign accept_w   = item_valid && !item_stall;
	assign run_ok_w   = CMP_W'(item.run) < n_w;
	assign run_addr_w = RUN_IDX_W'(item.run);
	assign busy_w     = head_present_q[run_addr_w] | run_finished_q[run_addr_w];
	assign wr_head_w  = accept_w && run_ok_w && !busy_w && (item.operation == OP_HEAD);
	assign wr_end_w   = accept_w && run_ok_w && !busy_w && (item.operation == OP_END);

	assign rd_en_w   = state_q == ST_SCAN;
	assign rd_addr_w = cnt_q[RUN_IDX_W-1:0];
	assign last_w    = cnt_q == (n_w - CMP_W'(1));

	assign take_w      = result_valid_q && !result_stall;
	assign slot_free_w = !result_valid_q || !result_stall;

	assign cfg_ready    = 1'b1;
	assign result_valid = result_valid_q;
	assign result       = result_q;

	kwm_ram #(
		.WIDTH (KEY_W),
		.DEPTH (MAX_RUNS)
	) u_heads (
		.clk     (clk),
		.wr_en   (wr_head_w),
		.wr_addr (run_addr_w),
		.wr_data ({item.key_high, item.key_low}),
		.rd_en   (rd_en_w),
		.rd_addr (rd_addr_w),
		.rd_data (rd_data_w)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			run_count_q    <= RUN_COUNT_RESET;
			head_present_q <= '0;
			run_finished_q <= '0;
			cnt_q          <= '0;
			found_q        <= 1'b0;
			done_q         <= 1'b0;
			sel_s1         <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				run_count_q <= cfg_data;
			end
			if ((state_q == ST_EMIT) && slot_free_w) begin
				result_valid_q <= 1'b1;
			end else if (take_w) begin
				result_valid_q <= 1'b0;
			end
			sel_s1 <= rd_en_w && head_present_q[rd_addr_w];
			// one shared 80-bit compare per cycle against the running best
			if (sel_s1 && (!found_q || (rd_data_w < best_key_q))) begin
				found_q <= 1'b1;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept_w) begin
						if (wr_head_w) begin
							head_present_q[run_addr_w] <= 1'b1;
						end
						if (wr_end_w) begin
							run_finished_q[run_addr_w] <= 1'b1;
						end
						state_q <= ST_CHECK;
					end
				end
				ST_CHECK: begin
					cnt_q   <= '0;
					found_q <= 1'b0;
					done_q  <= all_fin_w;
					if (!covered_w) begin
						state_q <= ST_IDLE;
					end else if (all_fin_w) begin
						state_q <= ST_EMIT;
					end else begin
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					cnt_q <= cnt_q + CMP_W'(1);
					if (last_w) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					// hold until the output register can take the result
					if (slot_free_w) begin
						if (done_q) begin
							head_present_q <= '0;
							run_finished_q <= '0;
						end else begin
							head_present_q[best_idx_q] <= 1'b0;
						end
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= rd_addr_w;
		if (sel_s1 && (!found_q || (rd_data_w < best_key_q))) begin
			best_key_q <= rd_data_w;
			best_idx_q <= idx_s1;
		end
		if ((state_q == ST_EMIT) && slot_free_w) begin
			if (done_q) begin
				result_q.winner_run   <= '0;
				result_q.out_key_high <= '0;
				result_q.out_key_low  <= '0;
				result_q.done_res     <= 1'b1;
			end else begin
				result_q.winner_run   <= RUN_W'(best_idx_q);
				result_q.out_key_high <= best_key_q[KEY_W-1:KEY_LOW_W];
				result_q.out_key_low  <= best_key_q[KEY_LOW_W-1:0];
				result_q.done_res     <= 1'b0;
			end
		end
	end

	a_flags_disjoint: assert property (@(posedge clk) disable iff (!arst_n)
		(head_present_q & run_finished_q) == '0)
		else $error("run holds a head and is marked ended");

	a_result_from_emit: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(state_q == ST_EMIT))
		else $error("result appeared outside the emit step");

	a_done_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT) && done_q && slot_free_w
		|=> (head_present_q == '0) && (run_finished_q == '0))
		else $error("flags not cleared after done result");

	a_key_found: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT) && !done_q |-> found_q)
		else $error("key result without a scanned head");

	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> (cnt_q < n_w))
		else $error("scan index beyond active runs");

endmodule

// ===== tb/sv/tb_kway_sorted_run_merger_top.sv =====
module tb_kway_sorted_run_merger_top
	import kwm_pkg::*;
	();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int NRUNS      = 8;
	localparam int SETTLE_CYC = 20;

	class merge_scoreboard;
		logic [RUN_COUNT_W-1:0] run_count;
		logic [KEY_HIGH_W-1:0]  head_top [NRUNS];
		logic [KEY_LOW_W-1:0]   head_rest [NRUNS];
		logic [NRUNS-1:0]       present;
		logic [NRUNS-1:0]       finished;
		result_t                queued_outputs [$];
		int                     errors;
		int                     key_results;
		int                     done_results;

		function new();
			run_count = RUN_COUNT_RESET;
			present = '0;
			finished = '0;
			errors = 0;
			key_results = 0;
			done_results = 0;
		endfunction

		function int unsigned active_runs();
			if (run_count == 0)
				return 1;
			if (run_count > NRUNS)
				return NRUNS;
			return run_count;
		endfunction

		function int pending();
			return queued_outputs.size();
		endfunction

		// Returns 1 when the item changed the merge state.
		function bit take_item(item_t it);
			int unsigned      n;
			logic [NRUNS-1:0] mask;
			bit               took;
			bit               found;
			int               best;
			result_t          r;
			n = active_runs();
			mask = '0;
			for (int i = 0; i < n; i++)
				mask[i] = 1'b1;
			took = 1'b0;
			if (it.run < n && !present[it.run] && !finished[it.run]) begin
				took = 1'b1;
				if (it.operation == OP_HEAD) begin
					head_top[it.run] = it.key_high;
					head_rest[it.run] = it.key_low;
					present[it.run] = 1'b1;
				end else begin
					finished[it.run] = 1'b1;
				end
			end
			if (((present | finished) & mask) != mask)
				return took;
			r = '0;
			if ((finished & mask) == mask) begin
				r.done_res = 1'b1;
				present = '0;
				finished = '0;
				done_results++;
				queued_outputs = {queued_outputs, r};
				return took;
			end
			found = 1'b0;
			best = 0;
			for (int i = 0; i < n; i++) begin
				if (!present[i])
					continue;
				// strict compare keeps the lowest run on equal keys
				if (!found || {head_top[i], head_rest[i]} < {head_top[best], head_rest[best]}) begin
					best = i;
					found = 1'b1;
				end
			end
			if (!found)
				return took;
			r.winner_run = RUN_W'(best);
			r.out_key_high = head_top[best];
			r.out_key_low = head_rest[best];
			present[best] = 1'b0;
			key_results++;
			queued_outputs = {queued_outputs, r};
			return took;
		endfunction

		function void check_output(result_t got);
			result_t want;
			if (queued_outputs.size() == 0) begin
				errors++;
				$display("%0t: unexpected result: expected none, actual run=%0d key=%h_%h done=%0b",
					$time, got.winner_run, got.out_key_high, got.out_key_low, got.done_res);
				return;
			end
			want = queued_outputs.pop_front();
			if (got.winner_run !== want.winner_run) begin
				errors++;
				$display("%0t: winner_run mismatch: expected %0d actual %0d",
					$time, want.winner_run, got.winner_run);
			end
			if (got.out_key_high !== want.out_key_high) begin
				errors++;
				$display("%0t: out_key_high mismatch: expected %h actual %h",
					$time, want.out_key_high, got.out_key_high);
			end
			if (got.out_key_low !== want.out_key_low) begin
				errors++;
				$display("%0t: out_key_low mismatch: expected %h actual %h",
					$time, want.out_key_low, got.out_key_low);
			end
			if (got.done_res !== want.done_res) begin
				errors++;
				$display("%0t: done_res mismatch: expected %0b actual %0b",
					$time, want.done_res, got.done_res);
			end
		endfunction
	endclass

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   item_valid = 1'b0;
	logic                   item_stall;
	item_t                  item = '0;
	logic                   result_valid;
	logic                   result_stall = 1'b0;
	result_t                result;
	logic                   cfg_valid = 1'b0;
	logic                   cfg_ready;
	logic [RUN_COUNT_W-1:0] cfg_data = '0;

	merge_scoreboard board = new();

	int accepted_cnt = 0;
	int ignored_cnt = 0;
	int settings_cnt = 0;
	int burst_left = 0;
	int stall_left = 0;
	int stall_mode = 0;
	int mode_left = 0;

	kway_sorted_run_merger_top #(
		.MAX_RUNS(NRUNS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.item(item),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	always begin
		#5ns clk = 1'b1;
		#5ns clk = 1'b0;
	end

	// Receiver: stall in short bursts, density switching between quiet, light and heavy.
	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall)
			board.check_output(result);
		if (mode_left == 0) begin
			stall_mode = $urandom_range(0, 2);
			mode_left = $urandom_range(50, 300);
		end else begin
			mode_left--;
		end
		if (stall_left > 0) begin
			stall_left--;
			result_stall <= 1'b1;
		end else if ((stall_mode == 1 && $urandom_range(0, 7) == 0) ||
				(stall_mode == 2 && $urandom_range(0, 1) == 0)) begin
			stall_left = $urandom_range(0, 5);
			result_stall <= 1'b1;
		end else begin
			result_stall <= 1'b0;
		end
	end

	function automatic item_t make_item(logic op, logic [RUN_W-1:0] run, logic [KEY_W-1:0] key);
		item_t it;
		it.operation = op;
		it.run = run;
		it.key_high = key[KEY_W-1:KEY_LOW_W];
		it.key_low = key[KEY_LOW_W-1:0];
		return it;
	endfunction

	// Mix of wide random keys and keys from narrow ranges so ties and near ties are common.
	function automatic logic [KEY_W-1:0] rand_key();
		logic [KEY_HIGH_W-1:0] hi;
		logic [KEY_LOW_W-1:0]  lo;
		logic [KEY_HIGH_W-1:0] hi_pool [4] = '{16'h0000, 16'h0001, 16'h8000, 16'hFFFF};
		logic [KEY_LOW_W-1:0]  lo_pool [4] = '{64'h0, 64'h1, 64'h8000_0000_0000_0000,
			64'hFFFF_FFFF_FFFF_FFFF};
		case ($urandom_range(0, 4))
			0: begin
				hi = KEY_HIGH_W'($urandom);
				lo = {$urandom, $urandom};
			end
			1: begin
				hi = KEY_HIGH_W'($urandom_range(0, 2));
				lo = KEY_LOW_W'($urandom_range(0, 2));
			end
			2: begin
				hi = hi_pool[$urandom_range(0, 3)];
				lo = lo_pool[$urandom_range(0, 3)];
			end
			3: begin
				hi = KEY_HIGH_W'($urandom_range(0, 1));
				lo = {$urandom, $urandom};
			end
			default: begin
				hi = KEY_HIGH_W'($urandom);
				lo = '0;
			end
		endcase
		return {hi, lo};
	endfunction

	task automatic push_item(item_t it);
		int gap;
		item_valid <= 1'b1;
		item <= it;
		do
			@(posedge clk);
		while (item_stall);
		if (board.take_item(it))
			accepted_cnt++;
		else
			ignored_cnt++;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 8);
			gap = $urandom_range(1, 12);
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Hold off until every expected result is out and the sequencer has settled.
	task automatic drain();
		item_valid <= 1'b0;
		while (board.pending() != 0)
			@(posedge clk);
		repeat (SETTLE_CYC) @(posedge clk);
	endtask

	task automatic write_run_count(logic [RUN_COUNT_W-1:0] value);
		drain();
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		board.run_count = value;
		settings_cnt++;
	endtask

	task automatic directed_merges();
		write_run_count(4'd2);
		push_item(make_item(OP_HEAD, 3'd0, {16'hFFFF, 64'hFFFF_FFFF_FFFF_FFFF}));
		// duplicate head, end while holding a head, run beyond the count: all dropped
		push_item(make_item(OP_HEAD, 3'd0, '0));
		push_item(make_item(OP_END, 3'd0, '0));
		push_item(make_item(OP_HEAD, 3'd5, {16'h1234, 64'h0}));
		push_item(make_item(OP_HEAD, 3'd1, '0));
		// equal top part, rest decides
		push_item(make_item(OP_HEAD, 3'd1, {16'hFFFF, 64'hFFFF_FFFF_FFFF_FFFE}));
		// top part decides, the rest parts being equal
		push_item(make_item(OP_HEAD, 3'd1, {16'h0001, 64'hFFFF_FFFF_FFFF_FFFF}));
		// equal keys: lower run wins
		push_item(make_item(OP_HEAD, 3'd1, {16'hFFFF, 64'hFFFF_FFFF_FFFF_FFFF}));
		push_item(make_item(OP_END, 3'd0, '1));
		push_item(make_item(OP_END, 3'd0, '0));
		push_item(make_item(OP_HEAD, 3'd0, {16'h5555, 64'hAAAA_AAAA_AAAA_AAAA}));
		push_item(make_item(OP_END, 3'd1, '0));
		// zero count acts as a single run
		write_run_count(4'd0);
		push_item(make_item(OP_HEAD, 3'd0, {16'hAAAA, 64'h5555_5555_5555_5555}));
		push_item(make_item(OP_HEAD, 3'd1, {16'h0000, 64'h0}));
		push_item(make_item(OP_END, 3'd0, '0));
		push_item(make_item(OP_END, 3'd7, '1));
		// count above the run limit acts as the full set
		write_run_count(4'd15);
		for (int r = 0; r < NRUNS; r++)
			push_item(make_item(OP_HEAD, RUN_W'(r), {16'h0042, 64'h42}));
	endtask

	// Mostly proper merges: feed only runs that are free, end each after a random
	// number of keys. The rest is stray items of any kind.
	task automatic run_merges(int target);
		int               done_seen;
		int               sent;
		int               r;
		int               picks [$];
		int               keys_left [NRUNS];
		int unsigned      n;
		logic [KEY_W-1:0] k;
		item_t            it;
		done_seen = -1;
		sent = 0;
		while (sent < target) begin
			if (board.done_results != done_seen) begin
				done_seen = board.done_results;
				foreach (keys_left[i])
					keys_left[i] = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 14) :
						$urandom_range(0, 5);
			end
			n = board.active_runs();
			picks.delete();
			for (r = 0; r < n; r++)
				if (!board.present[r] && !board.finished[r])
					picks = {picks, r};
			k = rand_key();
			if (picks.size() == 0 || $urandom_range(0, 99) < 12) begin
				it = make_item(($urandom_range(0, 1) == 1) ? OP_END : OP_HEAD,
					RUN_W'($urandom_range(0, NRUNS - 1)), k);
			end else begin
				r = picks[$urandom_range(0, picks.size() - 1)];
				if (keys_left[r] > 0) begin
					keys_left[r]--;
					it = make_item(OP_HEAD, RUN_W'(r), k);
				end else begin
					it = make_item(OP_END, RUN_W'(r), k);
				end
			end
			push_item(it);
			sent++;
		end
	endtask

	initial begin
		logic [RUN_COUNT_W-1:0] plan [12] = '{4'd1, 4'd8, 4'd3, 4'd15, 4'd2, 4'd0,
			4'd5, 4'd9, 4'd7, 4'd4, 4'd6, 4'd8};
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		directed_merges();
		run_merges(40);
		foreach (plan[p]) begin
			write_run_count(plan[p]);
			run_merges(142);
		end
		drain();
		$display("Accepted %0d items (%0d more ignored) over %0d run_count settings.",
			accepted_cnt, ignored_cnt, settings_cnt);
		$display("Checked %0d merged keys and %0d end-of-merge results.",
			board.key_results, board.done_results);
		if (board.errors == 0 && board.pending() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	initial begin
		#8ms;
		$display("Timeout: %0d results still expected", board.pending());
		$display("Test completed with failures");
		$finish;
	end

endmodule

// ===== filelist.f =====
hw/rtl/kwm_pkg.sv
hw/rtl/kwm_ram.sv
hw/rtl/kway_sorted_run_merger_top.sv
tb/sv/tb_kway_sorted_run_merger_top.sv
